### hdl/scsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsl_pkg
// Shared types and codes for the shortest common supersequence length block:
// request codes, the token kind that travels down the cell chain, and the
// fixed width and saturation limit of the reported length.
// ----------------------------------------------------------------------------
package scsl_pkg;

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_SECOND = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;

  localparam int unsigned SCS_W   = 10;
  localparam int unsigned LEN_SAT = 1023;

  typedef enum logic [1:0] {
    TOK_NONE,
    TOK_ROW,
    TOK_FIN
  } tok_kind_t;

endpackage

### hdl/shortest_common_supersequence_length_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_common_supersequence_length_top
// Shortest common supersequence length of two byte strings on a systolic
// row of MAX_LEN cells.
//
// Input channel (in_valid/in_ready, req_type, symbol): append a first-string
// byte, process a second-string byte, or finish. Append and second-string
// transactions are taken one per cycle while no finish is pending; each
// second-string byte enters cell 0 and sweeps the row as a skewed wavefront,
// one cell per cycle. A finish transaction sends a token down the row behind
// the last byte; it collects the final entry and restores each cell as it
// passes. The result appears on the output channel (out_valid/out_ready,
// scs_length, overflow, order_error) once the finish token has passed kind[0],
// every cell and the output register. in_ready stays low from the finish until
// the result transaction completes, so a stalled receiver holds off new input.
// Reset clears the counters and the sticky flags and restores every cell.
// ----------------------------------------------------------------------------
module shortest_common_supersequence_length_top #(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 req_type,
  input  logic [7:0]                 symbol,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [scsl_pkg::SCS_W-1:0] scs_length,
  output logic                       overflow,
  output logic                       order_error
);

  localparam int unsigned CW   = $clog2(2 * MAX_LEN + 1);
  localparam int unsigned CNTW = $clog2(MAX_LEN + 1);

  scsl_pkg::tok_kind_t kind [0:MAX_LEN];
  logic [7:0]          sym  [0:MAX_LEN];
  logic [CW-1:0]       left [0:MAX_LEN];
  logic [CW-1:0]       diag [0:MAX_LEN];
  logic [CNTW-1:0]     sel  [0:MAX_LEN];
  logic [CW-1:0]       res  [0:MAX_LEN];

  logic [CNTW-1:0] first_count;
  logic [CNTW-1:0] second_count;
  logic            in_second_phase;
  logic            overflow_flag;
  logic            order_flag;
  logic            busy;
  logic            fin_overflow;
  logic            fin_order;

  logic accept;
  logic app_en;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign app_en   = accept && (req_type == scsl_pkg::REQ_APPEND) && !in_second_phase
                    && (32'(first_count) < MAX_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      first_count     <= '0;
      second_count    <= '0;
      in_second_phase <= 1'b0;
      overflow_flag   <= 1'b0;
      order_flag      <= 1'b0;
      busy            <= 1'b0;
      kind[0]         <= scsl_pkg::TOK_NONE;
    end else begin
      kind[0] <= scsl_pkg::TOK_NONE;
      if (accept) begin
        case (req_type)
          scsl_pkg::REQ_APPEND: begin
            if (in_second_phase) begin
              order_flag <= 1'b1;
            end else if (32'(first_count) >= MAX_LEN) begin
              overflow_flag <= 1'b1;
            end else begin
              first_count <= first_count + CNTW'(1);
            end
          end
          scsl_pkg::REQ_SECOND: begin
            in_second_phase <= 1'b1;
            if (32'(second_count) >= MAX_LEN) begin
              overflow_flag <= 1'b1;
            end else begin
              second_count <= second_count + CNTW'(1);
              kind[0]      <= scsl_pkg::TOK_ROW;
            end
          end
          scsl_pkg::REQ_FINISH: begin
            kind[0]         <= scsl_pkg::TOK_FIN;
            busy            <= 1'b1;
            first_count     <= '0;
            second_count    <= '0;
            in_second_phase <= 1'b0;
            overflow_flag   <= 1'b0;
            order_flag      <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sym[0]  <= symbol;
    left[0] <= CW'(second_count) + CW'(1);
    diag[0] <= CW'(second_count);
    sel[0]  <= first_count;
    res[0]  <= CW'(second_count);
    if (accept && (req_type == scsl_pkg::REQ_FINISH)) begin
      fin_overflow <= overflow_flag;
      fin_order    <= order_flag;
    end
  end

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    scsl_cell #(
      .INDEX (i),
      .CW    (CW),
      .CNTW  (CNTW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (app_en && (first_count == CNTW'(i))),
      .wr_sym   (symbol),
      .in_kind  (kind[i]),
      .in_sym   (sym[i]),
      .in_left  (left[i]),
      .in_diag  (diag[i]),
      .in_sel   (sel[i]),
      .in_res   (res[i]),
      .out_kind (kind[i+1]),
      .out_sym  (sym[i+1]),
      .out_left (left[i+1]),
      .out_diag (diag[i+1]),
      .out_sel  (sel[i+1]),
      .out_res  (res[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (kind[MAX_LEN] == scsl_pkg::TOK_FIN) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (kind[MAX_LEN] == scsl_pkg::TOK_FIN) begin
      if (32'(res[MAX_LEN]) > scsl_pkg::LEN_SAT) begin
        scs_length <= scsl_pkg::SCS_W'(scsl_pkg::LEN_SAT);
      end else begin
        scs_length <= scsl_pkg::SCS_W'(res[MAX_LEN]);
      end
      overflow    <= fin_overflow;
      order_error <= fin_order;
    end
  end

endmodule

### hdl/scsl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsl_cell
// One cell of the systolic row. Holds one first-string byte and its entry of
// the current row; updates it as a row token passes and forwards the left
// and diagonal values to the next cell. A finish token picks up the final
// entry at the selected column and restores the entry to its start value.
// ----------------------------------------------------------------------------
module scsl_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CW    = 10,
  parameter int unsigned CNTW  = 9
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [7:0]          wr_sym,
  input  scsl_pkg::tok_kind_t in_kind,
  input  logic [7:0]          in_sym,
  input  logic [CW-1:0]       in_left,
  input  logic [CW-1:0]       in_diag,
  input  logic [CNTW-1:0]     in_sel,
  input  logic [CW-1:0]       in_res,
  output scsl_pkg::tok_kind_t out_kind,
  output logic [7:0]          out_sym,
  output logic [CW-1:0]       out_left,
  output logic [CW-1:0]       out_diag,
  output logic [CNTW-1:0]     out_sel,
  output logic [CW-1:0]       out_res
);

  logic [7:0]    sym_q;
  logic [CW-1:0] val;
  logic [CW-1:0] val_new;
  logic [CW-1:0] min_val;

  always_comb begin
    min_val = (val < in_left) ? val : in_left;
    if (sym_q == in_sym) begin
      val_new = in_diag + CW'(1);
    end else begin
      val_new = min_val + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sym_q <= wr_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val <= CW'(INDEX + 1);
    end else if (in_kind == scsl_pkg::TOK_ROW) begin
      val <= val_new;
    end else if (in_kind == scsl_pkg::TOK_FIN) begin
      val <= CW'(INDEX + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_kind <= scsl_pkg::TOK_NONE;
    end else begin
      out_kind <= in_kind;
    end
  end

  always_ff @(posedge clk) begin
    out_sym  <= in_sym;
    out_left <= val_new;
    out_diag <= val;
    out_sel  <= in_sel;
    out_res  <= (in_sel == CNTW'(INDEX + 1)) ? val : in_res;
  end

endmodule
